// File: hw/rtl/cdbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdbc_pkg: shared types and constants of the data block classifier
// Block kind codes, tag and extended tag codes, vendor OUIs and the record
// that carries one completed data block from the parser to the classifier.
// ----------------------------------------------------------------------------
package cdbc_pkg;

    // header tag codes
    localparam logic [2:0] TAG_AUDIO   = 3'd1;
    localparam logic [2:0] TAG_VIDEO   = 3'd2;
    localparam logic [2:0] TAG_VENDOR  = 3'd3;
    localparam logic [2:0] TAG_SPEAKER = 3'd4;
    localparam logic [2:0] TAG_EXT     = 3'd7;

    // extended tag codes
    localparam logic [7:0] ETAG_VCAP         = 8'd0;
    localparam logic [7:0] ETAG_VENDOR_VIDEO = 8'd1;
    localparam logic [7:0] ETAG_HDMI_VIDEO   = 8'd4;
    localparam logic [7:0] ETAG_COLORIMETRY  = 8'd5;
    localparam logic [7:0] ETAG_HDR_STATIC   = 8'd6;
    localparam logic [7:0] ETAG_HDR_DYNAMIC  = 8'd7;
    localparam logic [7:0] ETAG_VIDEO_PREF   = 8'd13;
    localparam logic [7:0] ETAG_YCC420_VIDEO = 8'd14;
    localparam logic [7:0] ETAG_YCC420_MAP   = 8'd15;
    localparam logic [7:0] ETAG_VENDOR_AUDIO = 8'd17;
    localparam logic [7:0] ETAG_HDMI_AUDIO   = 8'd18;
    localparam logic [7:0] ETAG_ROOM_CFG     = 8'd19;
    localparam logic [7:0] ETAG_SPEAKER_LOC  = 8'd20;
    localparam logic [7:0] ETAG_INFOFRAME    = 8'd32;
    localparam logic [7:0] ETAG_TIMING7      = 8'd34;
    localparam logic [7:0] ETAG_TIMING8      = 8'd35;
    localparam logic [7:0] ETAG_TIMING10     = 8'd42;
    localparam logic [7:0] ETAG_EXT_OVERRIDE = 8'd120;
    localparam logic [7:0] ETAG_SINK_CAP     = 8'd121;

    // vendor OUIs, first OUI byte in bits 7..0
    localparam logic [23:0] OUI_HDMI       = 24'h000C03;
    localparam logic [23:0] OUI_HDMI_FORUM = 24'hC45DD8;
    localparam logic [23:0] OUI_VRR_RANGE  = 24'h00001A;
    localparam logic [23:0] OUI_HDR_PLUS   = 24'h90848B;
    localparam logic [23:0] OUI_DV         = 24'h00D046;

    // configuration register indexes
    localparam logic CFG_MAX_DATA_SIZE   = 1'b0;
    localparam logic CFG_MAX_BLOCK_COUNT = 1'b1;

    // capability flag bits
    localparam int FLAG_HDMI      = 0;
    localparam int FLAG_HDMI20    = 1;
    localparam int FLAG_HDMI21    = 2;
    localparam int FLAG_AUDIO     = 3;
    localparam int FLAG_UNDERSCAN = 4;

    typedef enum logic [5:0] {
        KIND_END,
        KIND_AUDIO,
        KIND_VIDEO,
        KIND_HDMI,
        KIND_HDMI20,
        KIND_HDMI21,
        KIND_VRR_RANGE,
        KIND_VENDOR,
        KIND_SPEAKER,
        KIND_VCAP,
        KIND_VENDOR_VIDEO,
        KIND_HDR_PLUS_VIDEO,
        KIND_DV_VIDEO,
        KIND_HDMI_VIDEO,
        KIND_COLORIMETRY,
        KIND_HDR_STATIC,
        KIND_HDR_DYNAMIC,
        KIND_VIDEO_PREF,
        KIND_YCC420_VIDEO,
        KIND_YCC420_MAP,
        KIND_VENDOR_AUDIO,
        KIND_DV_AUDIO,
        KIND_HDMI_AUDIO,
        KIND_ROOM_CFG,
        KIND_SPEAKER_LOC,
        KIND_INFOFRAME,
        KIND_TIMING7,
        KIND_TIMING8,
        KIND_TIMING10,
        KIND_EXT_OVERRIDE,
        KIND_SINK_CAP,
        KIND_OTHER_EXT,
        KIND_OTHER
    } kind_t;

    // one completed data block, or an end marker
    typedef struct packed {
        logic            endmark;
        logic            clr;
        logic            at_end;
        logic [2:0]      tag;
        logic [5:0]      len;
        logic [5:0]      index;
        logic [7:1][7:0] body;
    } rec_t;

endpackage

// File: hw/rtl/cea_data_block_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cea_data_block_classifier_unit: data block collection classifier
// Walks a CEA-861 data block collection one byte per beat and emits one
// classified result per completed block or end marker.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                payload
//  item      in         item_valid/item_ready    data_byte, start_of_region
//  result    out        result_valid/result_ready block_kind .. region_end
//  config    in         cfg_write                cfg_index, cfg_data
//
//  one byte is taken every cycle while the record stage is not held; a
//  completed block passes the parser record, then the result register
//  reset leaves the parse state clear and the registers at 127 and 64
//  a held result stalls the record stage, and only then the byte input
// ----------------------------------------------------------------------------
module cea_data_block_classifier_unit
    import cdbc_pkg::*;
#(
    parameter int MAX_BYTES  = 128,
    parameter int MAX_BLOCKS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_of_region,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [5:0]  block_kind,
    output logic [5:0]  block_index,
    output logic [5:0]  block_length,
    output logic [23:0] vendor_id,
    output logic [10:0] link_rate,
    output logic [7:0]  range_low,
    output logic [7:0]  range_high,
    output logic [4:0]  capability_flags,
    output logic        region_end,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0] size_reg;
    logic [6:0] count_reg;
    logic       rec_valid;
    logic       rec_ready;
    rec_t       rec;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= 8'd127;
            count_reg <= 7'd64;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MAX_DATA_SIZE:   size_reg  <= cfg_data;
                CFG_MAX_BLOCK_COUNT: count_reg <= cfg_data[6:0];
                default:             size_reg  <= size_reg;
            endcase
        end
    end

    // byte parser
    cdbc_parser #(
        .MAX_BYTES  (MAX_BYTES),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .data_byte       (data_byte),
        .start_of_region (start_of_region),
        .max_data_size   (size_reg),
        .max_block_count (count_reg),
        .rec_valid       (rec_valid),
        .rec             (rec),
        .rec_ready       (rec_ready)
    );

    // classification and result register
    cdbc_classifier u_classifier (
        .clk              (clk),
        .rst_n            (rst_n),
        .rec_valid        (rec_valid),
        .rec              (rec),
        .rec_ready        (rec_ready),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .block_kind       (block_kind),
        .block_index      (block_index),
        .block_length     (block_length),
        .vendor_id        (vendor_id),
        .link_rate        (link_rate),
        .range_low        (range_low),
        .range_high       (range_high),
        .capability_flags (capability_flags),
        .region_end       (region_end)
    );

endmodule

// File: hw/rtl/cdbc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdbc_parser: byte-level walk of the data block collection
// Tracks offset, header length and body bytes; hands each completed block
// (or end marker) to the classifier as one registered record.
// ----------------------------------------------------------------------------
module cdbc_parser
    import cdbc_pkg::*;
#(
    parameter int MAX_BYTES  = 128,
    parameter int MAX_BLOCKS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] data_byte,
    input  logic       start_of_region,
    input  logic [7:0] max_data_size,
    input  logic [6:0] max_block_count,
    output logic       rec_valid,
    output rec_t       rec,
    input  logic       rec_ready
);

    localparam int         SEEN_W    = $clog2(MAX_BLOCKS + 1);
    localparam logic [8:0] BYTE_CAP  = 9'(MAX_BYTES);
    localparam logic [7:0] BLOCK_CAP = 8'(MAX_BLOCKS);

    logic [7:0]        offset_reg, offset_next;
    logic [4:0]        left_reg, left_next;
    logic [2:0]        tag_reg, tag_next;
    logic [5:0]        len_reg, len_next;
    logic [7:1][7:0]   body_reg, body_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic              pend_reg, pend_next;
    logic              rec_valid_reg, rec_valid_next;
    rec_t              rec_reg, rec_next;

    logic              accept;
    logic              emit;
    logic [8:0]        limit9;
    logic [7:0]        limit;
    logic [7:0]        blimit;
    logic [7:0]        ofs_c;
    logic [4:0]        left_c;
    logic [SEEN_W-1:0] seen_c;
    logic              live;
    logic              at_end;
    logic              seen_full;
    logic [7:0]        avail;
    logic [4:0]        size;
    logic [5:0]        k;

    assign item_ready = !rec_valid_reg || rec_ready;
    assign accept     = item_valid && item_ready;
    assign rec_valid  = rec_valid_reg;
    assign rec        = rec_reg;

    // effective limits and current position
    always_comb
    begin
        limit9    = ({1'b0, max_data_size} > BYTE_CAP) ? BYTE_CAP : {1'b0, max_data_size};
        limit     = limit9[7:0];
        blimit    = ({1'b0, max_block_count} > BLOCK_CAP) ? BLOCK_CAP
                                                          : {1'b0, max_block_count};
        ofs_c     = start_of_region ? 8'd0 : offset_reg;
        left_c    = start_of_region ? 5'd0 : left_reg;
        seen_c    = start_of_region ? '0 : seen_reg;
        live      = ofs_c < limit;
        at_end    = (ofs_c + 8'd1) == limit;
        seen_full = 8'(seen_c) >= blimit;
        avail     = limit - ofs_c - 8'd1;
        size      = ({3'b000, data_byte[4:0]} > avail) ? avail[4:0] : data_byte[4:0];
        k         = len_reg - {1'b0, left_reg};
    end

    // parse step for one accepted beat
    always_comb
    begin
        offset_next = offset_reg;
        left_next   = left_reg;
        tag_next    = tag_reg;
        len_next    = len_reg;
        body_next   = body_reg;
        seen_next   = seen_reg;
        emit        = 1'b0;
        rec_next    = rec_reg;
        if (accept)
        begin
            if (start_of_region)
            begin
                offset_next = '0;
                left_next   = '0;
                tag_next    = '0;
                len_next    = '0;
                body_next   = '0;
                seen_next   = '0;
            end
            if (live)
            begin
                if (left_c == 5'd0)
                begin
                    if (!seen_full)
                    begin
                        offset_next = ofs_c + 8'd1;
                        tag_next    = data_byte[7:5];
                        if (data_byte[7:5] == 3'd0 && size == 5'd0)
                        begin
                            // padding: end marker only on the last region byte
                            if (at_end)
                            begin
                                emit = 1'b1;
                                rec_next.endmark = 1'b1;
                                rec_next.tag     = 3'd0;
                                rec_next.len     = 6'd0;
                                rec_next.body    = '0;
                            end
                        end
                        else
                        begin
                            len_next  = {1'b0, size} + 6'd1;
                            body_next = '0;
                            if (size == 5'd0)
                            begin
                                emit      = 1'b1;
                                seen_next = seen_c + SEEN_W'(1);
                                rec_next.endmark = 1'b0;
                                rec_next.tag     = data_byte[7:5];
                                rec_next.len     = 6'd1;
                                rec_next.body    = '0;
                            end
                            else
                            begin
                                left_next = size;
                            end
                        end
                    end
                end
                else
                begin
                    // body byte: keep bytes 1..7 only
                    offset_next = ofs_c + 8'd1;
                    for (int i = 1; i <= 7; i++)
                    begin
                        if (k == 6'(i))
                        begin
                            body_next[i] = data_byte;
                        end
                    end
                    left_next = left_reg - 5'd1;
                    if (left_reg == 5'd1)
                    begin
                        emit      = 1'b1;
                        seen_next = seen_reg + SEEN_W'(1);
                        rec_next.endmark = 1'b0;
                        rec_next.tag     = tag_reg;
                        rec_next.len     = len_reg;
                        rec_next.body    = body_next;
                    end
                end
            end
            rec_next.index  = 6'(seen_c);
            rec_next.at_end = at_end;
            rec_next.clr    = pend_reg || start_of_region;
        end
        rec_valid_next = emit || (rec_valid_reg && !rec_ready);
        if (emit)
        begin
            pend_next = 1'b0;
        end
        else
        begin
            pend_next = pend_reg || (accept && start_of_region);
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            left_reg      <= '0;
            tag_reg       <= '0;
            len_reg       <= '0;
            body_reg      <= '0;
            seen_reg      <= '0;
            pend_reg      <= 1'b0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg    <= offset_next;
            left_reg      <= left_next;
            tag_reg       <= tag_next;
            len_reg       <= len_next;
            body_reg      <= body_next;
            seen_reg      <= seen_next;
            pend_reg      <= pend_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    // record payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rec_reg <= rec_next;
        end
    end

endmodule

// File: hw/rtl/cdbc_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdbc_classifier: block classification and result register
// Decodes kind, vendor ID, link rate and refresh range of one record and
// keeps the running capability flags.
// ----------------------------------------------------------------------------
module cdbc_classifier
    import cdbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rec_valid,
    input  rec_t        rec,
    output logic        rec_ready,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [5:0]  block_kind,
    output logic [5:0]  block_index,
    output logic [5:0]  block_length,
    output logic [23:0] vendor_id,
    output logic [10:0] link_rate,
    output logic [7:0]  range_low,
    output logic [7:0]  range_high,
    output logic [4:0]  capability_flags,
    output logic        region_end
);

    logic        valid_reg, valid_next;
    logic [4:0]  flags_reg, flags_next;
    logic [5:0]  kind_reg;
    logic [5:0]  index_reg;
    logic [5:0]  len_reg;
    logic [23:0] vid_reg, vid_next;
    logic [10:0] rate_reg, rate_next;
    logic [7:0]  lo_reg, lo_next;
    logic [7:0]  hi_reg, hi_next;
    logic        end_reg;

    logic        adv;
    kind_t       kind;
    logic [23:0] oui1;
    logic [23:0] oui2;
    logic [3:0]  r;
    logic [10:0] b5x5;
    logic [10:0] b7x5;
    logic [5:0]  len_out;

    assign rec_ready = !valid_reg || result_ready;
    assign adv       = rec_valid && rec_ready;
    assign oui1      = {rec.body[3], rec.body[2], rec.body[1]};
    assign oui2      = {rec.body[4], rec.body[3], rec.body[2]};
    assign r         = rec.body[7][7:4];
    assign b5x5      = {1'b0, rec.body[5], 2'b00} + {3'b000, rec.body[5]};
    assign b7x5      = {1'b0, rec.body[7], 2'b00} + {3'b000, rec.body[7]};
    assign len_out   = rec.endmark ? 6'd0 : rec.len;

    // kind from tag, vendor OUI and extended tag
    always_comb
    begin
        kind = KIND_OTHER;
        if (rec.endmark)
        begin
            kind = KIND_END;
        end
        else
        begin
            unique case (rec.tag)
                TAG_AUDIO: kind = KIND_AUDIO;
                TAG_VIDEO: kind = KIND_VIDEO;
                TAG_VENDOR:
                begin
                    if (rec.len < 6'd4)
                        kind = KIND_OTHER;
                    else if (rec.len >= 6'd6 && oui1 == OUI_HDMI)
                        kind = KIND_HDMI;
                    else if (rec.len >= 6'd8 && oui1 == OUI_HDMI_FORUM)
                        kind = (rec.len >= 6'd9 || r != 4'd0) ? KIND_HDMI21 : KIND_HDMI20;
                    else if (rec.len >= 6'd9 && oui1 == OUI_VRR_RANGE
                             && rec.body[6] != 8'd0 && rec.body[7] != 8'd0
                             && rec.body[6] <= rec.body[7])
                        kind = KIND_VRR_RANGE;
                    else
                        kind = KIND_VENDOR;
                end
                TAG_SPEAKER: kind = (rec.len < 6'd4) ? KIND_OTHER : KIND_SPEAKER;
                TAG_EXT:
                begin
                    if (rec.len < 6'd2)
                    begin
                        kind = KIND_OTHER;
                    end
                    else
                    begin
                        unique case (rec.body[1])
                            ETAG_VCAP:
                                kind = (rec.len < 6'd3) ? KIND_OTHER_EXT : KIND_VCAP;
                            ETAG_VENDOR_VIDEO:
                            begin
                                if (rec.len < 6'd5)
                                    kind = KIND_OTHER_EXT;
                                else if (oui2 == OUI_HDR_PLUS)
                                    kind = KIND_HDR_PLUS_VIDEO;
                                else if (oui2 == OUI_DV)
                                    kind = KIND_DV_VIDEO;
                                else
                                    kind = KIND_VENDOR_VIDEO;
                            end
                            ETAG_HDMI_VIDEO:   kind = KIND_HDMI_VIDEO;
                            ETAG_COLORIMETRY:
                                kind = (rec.len < 6'd4) ? KIND_OTHER_EXT : KIND_COLORIMETRY;
                            ETAG_HDR_STATIC:
                                kind = (rec.len < 6'd4) ? KIND_OTHER_EXT : KIND_HDR_STATIC;
                            ETAG_HDR_DYNAMIC:  kind = KIND_HDR_DYNAMIC;
                            ETAG_VIDEO_PREF:   kind = KIND_VIDEO_PREF;
                            ETAG_YCC420_VIDEO: kind = KIND_YCC420_VIDEO;
                            ETAG_YCC420_MAP:   kind = KIND_YCC420_MAP;
                            ETAG_VENDOR_AUDIO:
                            begin
                                if (rec.len < 6'd5)
                                    kind = KIND_OTHER_EXT;
                                else if (oui2 == OUI_DV)
                                    kind = KIND_DV_AUDIO;
                                else
                                    kind = KIND_VENDOR_AUDIO;
                            end
                            ETAG_HDMI_AUDIO:   kind = KIND_HDMI_AUDIO;
                            ETAG_ROOM_CFG:     kind = KIND_ROOM_CFG;
                            ETAG_SPEAKER_LOC:  kind = KIND_SPEAKER_LOC;
                            ETAG_INFOFRAME:    kind = KIND_INFOFRAME;
                            ETAG_TIMING7:      kind = KIND_TIMING7;
                            ETAG_TIMING8:      kind = KIND_TIMING8;
                            ETAG_TIMING10:     kind = KIND_TIMING10;
                            ETAG_EXT_OVERRIDE: kind = KIND_EXT_OVERRIDE;
                            ETAG_SINK_CAP:     kind = KIND_SINK_CAP;
                            default:           kind = KIND_OTHER_EXT;
                        endcase
                    end
                end
                default: kind = KIND_OTHER;
            endcase
        end
    end

    // vendor ID, link rate, refresh range and flags
    always_comb
    begin
        vid_next  = 24'd0;
        rate_next = 11'd0;
        lo_next   = 8'd0;
        hi_next   = 8'd0;
        case (kind)
            KIND_HDMI, KIND_HDMI20, KIND_HDMI21, KIND_VRR_RANGE, KIND_VENDOR:
                vid_next = oui1;
            KIND_VENDOR_VIDEO, KIND_HDR_PLUS_VIDEO, KIND_DV_VIDEO,
            KIND_VENDOR_AUDIO, KIND_DV_AUDIO:
                vid_next = oui2;
            default:
                vid_next = 24'd0;
        endcase
        if (kind == KIND_HDMI && rec.len > 6'd7)
        begin
            rate_next = b7x5;
        end
        else if ((kind == KIND_HDMI20 || kind == KIND_HDMI21) && rec.len > 6'd7)
        begin
            // FRL code in the top nibble of byte 7
            if (r == 4'd0)
                rate_next = b5x5;
            else if (r <= 4'd2)
                rate_next = {4'b0000, r, 3'b000} + {7'd0, r};
            else if (r <= 4'd6)
                rate_next = {4'd0, r, 3'b000};
            else
                rate_next = 11'd0;
        end
        if (kind == KIND_VRR_RANGE)
        begin
            lo_next = rec.body[6];
            hi_next = rec.body[7];
        end
        flags_next = rec.clr ? 5'd0 : flags_reg;
        if (kind == KIND_HDMI)
            flags_next[FLAG_HDMI] = 1'b1;
        if (kind == KIND_HDMI20)
            flags_next[FLAG_HDMI20] = 1'b1;
        if (kind == KIND_HDMI21)
            flags_next[FLAG_HDMI21] = 1'b1;
        if (kind == KIND_AUDIO || kind == KIND_SPEAKER)
            flags_next[FLAG_AUDIO] = 1'b1;
        if (kind == KIND_VCAP && rec.body[2][3:2] == 2'b10)
            flags_next[FLAG_UNDERSCAN] = 1'b1;
        valid_next = adv || (valid_reg && !result_ready);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (adv)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_reg  <= 6'(kind);
            index_reg <= rec.index;
            len_reg   <= len_out;
            vid_reg   <= vid_next;
            rate_reg  <= rate_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            end_reg   <= rec.at_end;
        end
    end

    assign result_valid     = valid_reg;
    assign block_kind       = kind_reg;
    assign block_index      = index_reg;
    assign block_length     = len_reg;
    assign vendor_id        = vid_reg;
    assign link_rate        = rate_reg;
    assign range_low        = lo_reg;
    assign range_high       = hi_reg;
    assign capability_flags = flags_reg;
    assign region_end       = end_reg;

endmodule

// File: bench/tb_cea_data_block_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cea_data_block_classifier_unit: testbench of the data block classifier
// Sends data block collections one byte per beat and keeps a local model of
// the parser and classifier. Every result beat is compared field by field
// with the oldest predicted block, under random idling on both channels and
// several register settings.
// ----------------------------------------------------------------------------
module tb_cea_data_block_classifier_unit;
    import cdbc_pkg::*;

    localparam int BYTE_LIMIT  = 128;
    localparam int BLOCK_LIMIT = 64;
    localparam int MAX_PRINTS  = 60;

    // one predicted result beat
    typedef struct {
        kind_t       kind;
        logic [5:0]  index;
        logic [5:0]  length;
        logic [23:0] vendor;
        logic [10:0] rate;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [4:0]  flags;
        logic        at_end;
    } block_result_t;

    logic        clk;
    logic        rst_n           = 1'b0;
    logic        item_valid      = 1'b0;
    logic        item_ready;
    logic [7:0]  data_byte       = 8'h00;
    logic        start_of_region = 1'b0;
    logic        result_valid;
    logic        result_ready    = 1'b0;
    logic [5:0]  block_kind;
    logic [5:0]  block_index;
    logic [5:0]  block_length;
    logic [23:0] vendor_id;
    logic [10:0] link_rate;
    logic [7:0]  range_low;
    logic [7:0]  range_high;
    logic [4:0]  capability_flags;
    logic        region_end;
    logic        cfg_write       = 1'b0;
    logic        cfg_index       = 1'b0;
    logic [7:0]  cfg_data        = 8'h00;

    // predictor copy of registers and parse state
    int unsigned   size_reg;
    int unsigned   count_reg;
    int unsigned   offset;
    int unsigned   left;
    logic [2:0]    cur_tag;
    int unsigned   cur_len;
    int unsigned   seen;
    logic [7:0]    body [1:7];
    logic [4:0]    flags;

    block_result_t pending_blocks [$];
    logic [7:0]    region_bytes [$];
    int            errors        = 0;
    int            results_seen  = 0;
    int            bytes_sent    = 0;
    int            sender_idle   = 24;
    int            receiver_idle = 87;

    cea_data_block_classifier_unit #(
        .MAX_BYTES  (BYTE_LIMIT),
        .MAX_BLOCKS (BLOCK_LIMIT)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .data_byte        (data_byte),
        .start_of_region  (start_of_region),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .block_kind       (block_kind),
        .block_index      (block_index),
        .block_length     (block_length),
        .vendor_id        (vendor_id),
        .link_rate        (link_rate),
        .range_low        (range_low),
        .range_high       (range_high),
        .capability_flags (capability_flags),
        .region_end       (region_end),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic void clear_parse_state();
        offset  = 0;
        left    = 0;
        cur_tag = '0;
        cur_len = 0;
        seen    = 0;
        flags   = '0;
        for (int k = 1; k <= 7; k++)
            body[k] = '0;
    endfunction

    // kind from tag, clamped length and stored body bytes
    function automatic kind_t classify_block(logic [2:0] tag, int unsigned len);
        logic [23:0] oui_a;
        logic [23:0] oui_b;
        oui_a = {body[3], body[2], body[1]};
        oui_b = {body[4], body[3], body[2]};
        case (tag)
            TAG_AUDIO: return KIND_AUDIO;
            TAG_VIDEO: return KIND_VIDEO;
            TAG_VENDOR:
            begin
                if (len < 4)
                    return KIND_OTHER;
                if (len >= 6 && oui_a == OUI_HDMI)
                    return KIND_HDMI;
                if (len >= 8 && oui_a == OUI_HDMI_FORUM)
                    return (len >= 9 || body[7][7:4] != 4'd0) ? KIND_HDMI21 : KIND_HDMI20;
                if (len >= 9 && oui_a == OUI_VRR_RANGE && body[6] != 8'd0 &&
                    body[7] != 8'd0 && body[6] <= body[7])
                    return KIND_VRR_RANGE;
                return KIND_VENDOR;
            end
            TAG_SPEAKER: return (len < 4) ? KIND_OTHER : KIND_SPEAKER;
            TAG_EXT:
            begin
                if (len < 2)
                    return KIND_OTHER;
                case (body[1])
                    ETAG_VCAP:         return (len < 3) ? KIND_OTHER_EXT : KIND_VCAP;
                    ETAG_VENDOR_VIDEO:
                    begin
                        if (len < 5)
                            return KIND_OTHER_EXT;
                        if (oui_b == OUI_HDR_PLUS)
                            return KIND_HDR_PLUS_VIDEO;
                        if (oui_b == OUI_DV)
                            return KIND_DV_VIDEO;
                        return KIND_VENDOR_VIDEO;
                    end
                    ETAG_HDMI_VIDEO:   return KIND_HDMI_VIDEO;
                    ETAG_COLORIMETRY:  return (len < 4) ? KIND_OTHER_EXT : KIND_COLORIMETRY;
                    ETAG_HDR_STATIC:   return (len < 4) ? KIND_OTHER_EXT : KIND_HDR_STATIC;
                    ETAG_HDR_DYNAMIC:  return KIND_HDR_DYNAMIC;
                    ETAG_VIDEO_PREF:   return KIND_VIDEO_PREF;
                    ETAG_YCC420_VIDEO: return KIND_YCC420_VIDEO;
                    ETAG_YCC420_MAP:   return KIND_YCC420_MAP;
                    ETAG_VENDOR_AUDIO:
                    begin
                        if (len < 5)
                            return KIND_OTHER_EXT;
                        return (oui_b == OUI_DV) ? KIND_DV_AUDIO : KIND_VENDOR_AUDIO;
                    end
                    ETAG_HDMI_AUDIO:   return KIND_HDMI_AUDIO;
                    ETAG_ROOM_CFG:     return KIND_ROOM_CFG;
                    ETAG_SPEAKER_LOC:  return KIND_SPEAKER_LOC;
                    ETAG_INFOFRAME:    return KIND_INFOFRAME;
                    ETAG_TIMING7:      return KIND_TIMING7;
                    ETAG_TIMING8:      return KIND_TIMING8;
                    ETAG_TIMING10:     return KIND_TIMING10;
                    ETAG_EXT_OVERRIDE: return KIND_EXT_OVERRIDE;
                    ETAG_SINK_CAP:     return KIND_SINK_CAP;
                    default:           return KIND_OTHER_EXT;
                endcase
            end
            default: return KIND_OTHER;
        endcase
    endfunction

    // completed block: derive fields, update running flags, queue the result
    function automatic void finish_block(logic at_end);
        block_result_t r;
        int unsigned   speed;
        r.kind   = classify_block(cur_tag, cur_len);
        r.vendor = '0;
        r.rate   = '0;
        r.lo     = '0;
        r.hi     = '0;
        if (r.kind inside {KIND_HDMI, KIND_HDMI20, KIND_HDMI21, KIND_VRR_RANGE, KIND_VENDOR})
            r.vendor = {body[3], body[2], body[1]};
        else if (r.kind inside {KIND_VENDOR_VIDEO, KIND_HDR_PLUS_VIDEO, KIND_DV_VIDEO,
                                KIND_VENDOR_AUDIO, KIND_DV_AUDIO})
            r.vendor = {body[4], body[3], body[2]};

        // link rate: tmds clock or frl rate
        if (r.kind == KIND_HDMI && cur_len > 7)
            r.rate = 11'(body[7] * 5);
        else if ((r.kind == KIND_HDMI20 || r.kind == KIND_HDMI21) && cur_len > 7)
        begin
            speed = body[7][7:4];
            if (speed == 0)
                r.rate = 11'(body[5] * 5);
            else if (speed <= 2)
                r.rate = 11'(speed * 9);
            else if (speed <= 6)
                r.rate = 11'(speed * 8);
        end
        if (r.kind == KIND_VRR_RANGE)
        begin
            r.lo = body[6];
            r.hi = body[7];
        end

        if (r.kind == KIND_HDMI)
            flags[FLAG_HDMI] = 1'b1;
        if (r.kind == KIND_HDMI20)
            flags[FLAG_HDMI20] = 1'b1;
        if (r.kind == KIND_HDMI21)
            flags[FLAG_HDMI21] = 1'b1;
        if (r.kind == KIND_AUDIO || r.kind == KIND_SPEAKER)
            flags[FLAG_AUDIO] = 1'b1;
        if (r.kind == KIND_VCAP && body[2][3:2] == 2'b10)
            flags[FLAG_UNDERSCAN] = 1'b1;

        r.index  = 6'(seen);
        r.length = 6'(cur_len);
        r.flags  = flags;
        r.at_end = at_end;
        pending_blocks.push_back(r);
        seen++;
    endfunction

    // one accepted byte beat
    function automatic void parse_byte(logic [7:0] d, logic sor);
        int unsigned   limit;
        int unsigned   blimit;
        int unsigned   pos;
        int unsigned   size;
        int unsigned   k;
        logic          at_end;
        block_result_t r;
        limit  = (size_reg < BYTE_LIMIT) ? size_reg : BYTE_LIMIT;
        blimit = (count_reg < BLOCK_LIMIT) ? count_reg : BLOCK_LIMIT;
        if (sor)
            clear_parse_state();
        pos = offset;
        if (pos >= limit)
            return;
        at_end = (pos + 1 == limit);

        if (left == 0)
        begin
            // header byte
            if (seen >= blimit)
                return;
            offset  = pos + 1;
            cur_tag = d[7:5];
            size    = d[4:0];
            if (size > limit - pos - 1)
                size = limit - pos - 1;
            if (cur_tag == 3'd0 && size == 0)
            begin
                // padding; only the last region byte yields an end marker
                if (at_end)
                begin
                    r.kind   = KIND_END;
                    r.index  = 6'(seen);
                    r.length = '0;
                    r.vendor = '0;
                    r.rate   = '0;
                    r.lo     = '0;
                    r.hi     = '0;
                    r.flags  = flags;
                    r.at_end = 1'b1;
                    pending_blocks.push_back(r);
                end
                return;
            end
            cur_len = size + 1;
            for (int j = 1; j <= 7; j++)
                body[j] = '0;
            if (size == 0)
                finish_block(at_end);
            else
                left = size;
        end
        else
        begin
            // body byte, only 1..7 kept
            offset = pos + 1;
            k      = cur_len - left;
            if (k >= 1 && k <= 7)
                body[k] = d;
            left--;
            if (left == 0)
                finish_block(at_end);
        end
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    task automatic report_error(input string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [23:0] got,
                               input logic [23:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                   results_seen, name, got, want));
    endtask

    task automatic check_result();
        block_result_t want;
        if (pending_blocks.size() == 0)
        begin
            report_error($sformatf("result beat with no block pending, kind %0d", block_kind));
            return;
        end
        want = pending_blocks.pop_front();
        check_field("block_kind", block_kind, want.kind);
        check_field("block_index", block_index, want.index);
        check_field("block_length", block_length, want.length);
        check_field("vendor_id", vendor_id, want.vendor);
        check_field("link_rate", link_rate, want.rate);
        check_field("range_low", range_low, want.lo);
        check_field("range_high", range_high, want.hi);
        check_field("capability_flags", capability_flags, want.flags);
        check_field("region_end", region_end, want.at_end);
        results_seen++;
    endtask

    // result beats and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            check_result();
        result_ready <= ($urandom_range(0, 99) >= receiver_idle);
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one byte beat, with random sender gaps ahead of it
    task automatic send_byte(input logic [7:0] d, input logic sor);
        while ($urandom_range(0, 99) < sender_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid      <= 1'b1;
        data_byte       <= d;
        start_of_region <= sor;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        parse_byte(d, sor);
        bytes_sent++;
    endtask

    task automatic stop_sending();
        item_valid <= 1'b0;
    endtask

    // sender holds off until every predicted block has come out
    task automatic wait_blocks_done();
        stop_sending();
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_MAX_DATA_SIZE)
            size_reg = val;
        else
            count_reg = val[6:0];
        @(posedge clk);
    endtask

    task automatic configure(input int unsigned size, input int unsigned count);
        wait_blocks_done();
        write_reg(CFG_MAX_DATA_SIZE, 8'(size));
        write_reg(CFG_MAX_BLOCK_COUNT, 8'(count));
    endtask

    function automatic logic [7:0] pick_ext_tag();
        case ($urandom_range(0, 22))
            0:  return ETAG_VCAP;
            1:  return ETAG_VENDOR_VIDEO;
            2:  return ETAG_HDMI_VIDEO;
            3:  return ETAG_COLORIMETRY;
            4:  return ETAG_HDR_STATIC;
            5:  return ETAG_HDR_DYNAMIC;
            6:  return ETAG_VIDEO_PREF;
            7:  return ETAG_YCC420_VIDEO;
            8:  return ETAG_YCC420_MAP;
            9:  return ETAG_VENDOR_AUDIO;
            10: return ETAG_HDMI_AUDIO;
            11: return ETAG_ROOM_CFG;
            12: return ETAG_SPEAKER_LOC;
            13: return ETAG_INFOFRAME;
            14: return ETAG_TIMING7;
            15: return ETAG_TIMING8;
            16: return ETAG_TIMING10;
            17: return ETAG_EXT_OVERRIDE;
            18: return ETAG_SINK_CAP;
            default: return 8'($urandom);
        endcase
    endfunction

    // append one random block, padding byte or noise byte to the region
    function automatic void append_block();
        logic [7:0]  gen [1:31];
        logic [2:0]  tag;
        logic [23:0] oui;
        int unsigned pick;
        int unsigned len;
        for (int k = 1; k <= 31; k++)
            gen[k] = 8'($urandom);
        pick = $urandom_range(0, 99);
        len  = $urandom_range(0, 8);
        tag  = 3'($urandom);
        if (pick < 12)
        begin
            // any tag, sometimes long
            if ($urandom_range(0, 3) == 0)
                len = $urandom_range(9, 31);
        end
        else if (pick < 22)
        begin
            case ($urandom_range(0, 2))
                0:       tag = TAG_AUDIO;
                1:       tag = TAG_VIDEO;
                default: tag = TAG_SPEAKER;
            endcase
            len = $urandom_range(0, 6);
        end
        else if (pick < 50)
        begin
            // vendor block with a known or random oui
            tag = TAG_VENDOR;
            case ($urandom_range(0, 3))
                0:       oui = OUI_HDMI;
                1:       oui = OUI_HDMI_FORUM;
                2:       oui = OUI_VRR_RANGE;
                default: oui = 24'($urandom);
            endcase
            {gen[3], gen[2], gen[1]} = oui;
            len = $urandom_range(2, 11);
            if (oui == OUI_HDMI_FORUM && $urandom_range(0, 1) == 0)
            begin
                len = 7;
                if ($urandom_range(0, 1) == 0)
                    gen[7][7:4] = 4'd0;
            end
            if (oui == OUI_VRR_RANGE && $urandom_range(0, 2) != 0)
                gen[7] = gen[6] + 8'($urandom_range(0, 60));
            if ($urandom_range(0, 15) == 0)
                len = $urandom_range(12, 31);
        end
        else if (pick < 85)
        begin
            // extended tag block
            tag    = TAG_EXT;
            gen[1] = pick_ext_tag();
            case ($urandom_range(0, 3))
                0:       {gen[4], gen[3], gen[2]} = OUI_HDR_PLUS;
                1:       {gen[4], gen[3], gen[2]} = OUI_DV;
                default: ;
            endcase
            if (gen[1] == ETAG_VCAP && $urandom_range(0, 1) == 0)
                gen[2][3:2] = 2'b10;
        end
        else if (pick < 93)
        begin
            tag = 3'd0;
            len = 0;
        end
        else
        begin
            region_bytes.push_back(8'($urandom));
            return;
        end
        region_bytes.push_back({tag, 5'(len)});
        for (int k = 1; k <= len; k++)
            region_bytes.push_back(gen[k]);
    endfunction

    // one collection, start flag on its first byte
    task automatic send_region();
        int unsigned limit;
        int unsigned target;
        int unsigned style;
        limit  = (size_reg < BYTE_LIMIT) ? size_reg : BYTE_LIMIT;
        target = limit + $urandom_range(1, 4);
        style  = $urandom_range(0, 9);
        region_bytes.delete();
        if (style == 0)
            target = $urandom_range(1, target);
        if (style == 1)
        begin
            // blocks, then zero padding up to and past the end
            while (region_bytes.size() + 4 < limit)
                append_block();
            while (region_bytes.size() < target)
                region_bytes.push_back(8'h00);
        end
        while (region_bytes.size() < target)
            append_block();
        // cut short: the next region starts in the middle of a block
        while (style == 0 && region_bytes.size() > target)
            void'(region_bytes.pop_back());
        for (int i = 0; i < region_bytes.size(); i++)
            send_byte(region_bytes[i], i == 0);
    endtask

    function automatic int unsigned pick_size();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return BYTE_LIMIT;
            2:       return 255;
            3:       return 127;
            4, 5, 6: return $urandom_range(1, 16);
            default: return $urandom_range(17, BYTE_LIMIT);
        endcase
    endfunction

    function automatic int unsigned pick_count();
        case ($urandom_range(0, 15))
            0:       return 0;
            1, 2:    return $urandom_range(1, 4);
            3:       return 127;
            4:       return $urandom_range(65, 126);
            5, 6, 7: return $urandom_range(5, 63);
            default: return BLOCK_LIMIT;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset settings: hdmi block with rate, zero-length audio, padding, underscan
    task automatic test_basic_blocks();
        send_byte(8'h67, 1'b1);
        send_byte(8'h03, 1'b0);
        send_byte(8'h0C, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hC8, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(ETAG_VCAP, 1'b0);
        send_byte(8'h0A, 1'b0);
    endtask

    // tiny regions: end marker on the last byte, clamping, bytes past the end
    task automatic test_region_edges();
        configure(4, 2);
        send_byte(8'h00, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        configure(2, BLOCK_LIMIT);
        send_byte(8'hFF, 1'b1);
        send_byte(ETAG_HDR_DYNAMIC, 1'b0);
        configure(0, 0);
        send_byte(8'h20, 1'b1);
    endtask

    // block limit of one, oversized region register
    task automatic test_block_limit();
        configure(255, 1);
        send_byte(8'h20, 1'b1);
        send_byte(8'h40, 1'b0);
    endtask

    // run of zero-length blocks up to the full block count
    task automatic test_index_wrap();
        configure(BYTE_LIMIT, 100);
        for (int i = 0; i < 70; i++)
            send_byte({3'($urandom_range(1, 7)), 5'd0}, i == 0);
    endtask

    // region size lowered and raised again in the middle of a block
    task automatic test_midblock_resize();
        configure(127, BLOCK_LIMIT);
        send_byte(8'h7F, 1'b1);
        for (int i = 0; i < 5; i++)
            send_byte(8'($urandom), 1'b0);
        configure(3, BLOCK_LIMIT);
        for (int i = 0; i < 5; i++)
            send_byte(8'($urandom), 1'b0);
        configure(40, BLOCK_LIMIT);
        for (int i = 0; i < 40; i++)
            send_byte(8'($urandom), 1'b0);
    endtask

    // random collections under one idling pattern
    task automatic test_random_traffic(input int s_idle, input int r_idle, input int items);
        int start;
        sender_idle   = s_idle;
        receiver_idle = r_idle;
        start         = bytes_sent;
        while (bytes_sent - start < items)
        begin
            if ($urandom_range(0, 2) == 0)
                configure(pick_size(), pick_count());
            send_region();
        end
        wait_blocks_done();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        size_reg  = 127;
        count_reg = BLOCK_LIMIT;
        clear_parse_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_blocks();
        test_region_edges();
        test_block_limit();
        test_index_wrap();
        test_midblock_resize();
        test_random_traffic(24, 87, 330);
        test_random_traffic(87, 24, 330);
        test_random_traffic(0, 0, 330);

        // drain and settle
        stop_sending();
        for (int n = 0; n < 50000 && pending_blocks.size() != 0; n++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (pending_blocks.size() != 0)
            report_error($sformatf("%0d predicted blocks never came out",
                                   pending_blocks.size()));
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
